FILE: src/ngls_pkg.sv
// Shared types and constants for the nearest goal or leader select block.
`timescale 1ns / 1ps

package ngls_pkg;

    // Fixed field widths of the transaction payloads and the default table size.
    localparam int COORD_BITS     = 16;
    localparam int SLOT_W         = 6;
    localparam int ACTIVE_W       = 7;
    localparam int ROLE_W         = 2;
    localparam int OUTCOME_W      = 2;
    localparam int GOAL_CAPACITY_DEF = 64;

    // Operation codes of an input transaction.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Role codes of a query.
    localparam logic [ROLE_W-1:0] ROLE_LEADER   = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_FOLLOWER = 2'd1;

    // Result outcome codes.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NEAREST  = 2'd0,
        OUT_LEADER   = 2'd1,
        OUT_DEFAULT  = 2'd2,
        OUT_NO_GOALS = 2'd3
    } t_outcome;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     write_goal;
        logic     load_query;
        logic     read_goal;
        logic     load_out;
        t_outcome outcome;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

FILE: src/ngls_ctrl.sv
// Controller state machine: handshakes, configuration register and search sequencing.
`timescale 1ns / 1ps

module ngls_ctrl #(
    parameter int GOAL_CAPACITY = 64,
    parameter int IDX_W         = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [ngls_pkg::ROLE_W-1:0]  i_role,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ngls_pkg::ACTIVE_W-1:0] i_cfg_active_goals,
    output ngls_pkg::t_dp_cmd            o_cmd,
    output logic [IDX_W-1:0]             o_rd_addr,
    input  ngls_pkg::t_dp_status         i_status
);
    import ngls_pkg::*;

    localparam int CNT_W = $clog2(GOAL_CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_addr, n_addr;
    logic [IDX_W-1:0]      r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    logic [ACTIVE_W-1:0]   r_active_goals, n_active_goals;

    logic [CMP_W-1:0]      active_ext;
    logic [CNT_W-1:0]      eff_count;
    logic [CNT_W-1:0]      count_m1;
    logic                  in_fire;
    logic                  out_slot_free;
    t_outcome              query_outcome;

    // Number of entries searched, limited to the table size.
    always_comb begin
        active_ext = CMP_W'(r_active_goals);
        if (active_ext > CMP_W'(GOAL_CAPACITY)) begin
            eff_count = CNT_W'(GOAL_CAPACITY);
        end else begin
            eff_count = CNT_W'(active_ext);
        end
        count_m1 = eff_count - CNT_W'(1);
    end

    // Outcome class of a query, decided when it is accepted.
    always_comb begin
        if (i_role == ROLE_LEADER) begin
            query_outcome = (eff_count == '0) ? OUT_NO_GOALS : OUT_NEAREST;
        end else if (i_role == ROLE_FOLLOWER) begin
            query_outcome = OUT_LEADER;
        end else begin
            query_outcome = OUT_DEFAULT;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign out_slot_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_last         = r_last;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_active_goals = r_active_goals;
        o_cmd          = '0;
        o_cmd.outcome  = query_outcome;

        if (i_cfg_valid) begin
            n_active_goals = i_cfg_active_goals;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.write_goal = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_addr           = '0;
                        n_last           = IDX_W'(count_m1);
                        n_state = (query_outcome == OUT_NEAREST) ? S_SEARCH : S_RESULT;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.read_goal = 1'b1;
                n_addr          = r_addr + IDX_W'(1);
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_addr         <= '0;
            r_last         <= '0;
            r_out_valid    <= 1'b0;
            r_active_goals <= '0;
        end else begin
            r_state        <= n_state;
            r_addr         <= n_addr;
            r_last         <= n_last;
            r_out_valid    <= n_out_valid;
            r_active_goals <= n_active_goals;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_rd_addr   = r_addr;

endmodule

FILE: src/ngls_dpath.sv
// Datapath: goal table memory, distance pipeline, running minimum and result registers.
`timescale 1ns / 1ps

module ngls_dpath #(
    parameter int GOAL_CAPACITY = 64,
    parameter int IDX_W         = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ngls_pkg::t_dp_cmd                     i_cmd,
    input  logic [IDX_W-1:0]                      i_rd_addr,
    output ngls_pkg::t_dp_status                  o_status,
    input  logic [ngls_pkg::SLOT_W-1:0]           i_goal_slot,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_point_y,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_leader_x,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_leader_y,
    output ngls_pkg::t_outcome                    o_outcome,
    output logic [ngls_pkg::SLOT_W-1:0]           o_chosen_index,
    output logic signed [ngls_pkg::COORD_BITS-1:0] o_target_x,
    output logic signed [ngls_pkg::COORD_BITS-1:0] o_target_y
);
    import ngls_pkg::*;

    localparam int CNT_W  = $clog2(GOAL_CAPACITY + 1);
    localparam int SCMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;

    // Goal table, x in the upper half and y in the lower half of each word.
    logic [2*COORD_BITS-1:0] mem [GOAL_CAPACITY];

    // Query context.
    t_outcome                r_outcome;
    logic [COORD_BITS-1:0]   r_px, r_py, r_lx, r_ly;

    // Stage 1: registered table read.
    logic                    r_v1;
    logic [IDX_W-1:0]        r_idx1;
    logic [2*COORD_BITS-1:0] r_rd_data;

    // Stage 2: squared differences.
    logic                    r_v2;
    logic [IDX_W-1:0]        r_idx2;
    logic [COORD_BITS-1:0]   r_x2, r_y2;
    logic [SQ_W-1:0]         r_sqx, r_sqy;

    // Stage 3: running minimum.
    logic                    r_first;
    logic [SUM_W-1:0]        r_best_dist;
    logic [IDX_W-1:0]        r_best_idx;
    logic [COORD_BITS-1:0]   r_best_x, r_best_y;

    // Result registers.
    t_outcome                r_out_outcome;
    logic [SLOT_W-1:0]       r_out_index;
    logic [COORD_BITS-1:0]   r_out_x, r_out_y;

    logic                    slot_in_range;
    logic [COORD_BITS-1:0]   gx, gy;
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [SQ_W-1:0]  px2, py2;
    logic [SUM_W-1:0]        cand_dist;
    logic                    take;

    assign slot_in_range = (SCMP_W'(i_goal_slot) < SCMP_W'(GOAL_CAPACITY));

    // Table write on a write transaction, registered read during the search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_goal && slot_in_range) begin
            mem[IDX_W'(i_goal_slot)] <= {i_point_x, i_point_y};
        end
        if (i_cmd.read_goal) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Differences and squares of the entry read in stage 1.
    always_comb begin
        gx   = r_rd_data[2*COORD_BITS-1:COORD_BITS];
        gy   = r_rd_data[COORD_BITS-1:0];
        dx   = $signed({gx[COORD_BITS-1], gx}) - $signed({r_px[COORD_BITS-1], r_px});
        dy   = $signed({gy[COORD_BITS-1], gy}) - $signed({r_py[COORD_BITS-1], r_py});
        px2  = dx * dx;
        py2  = dy * dy;
    end

    // Sum of squares and compare against the best so far; the first entry always wins.
    assign cand_dist = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    assign take      = r_v2 && (r_first || (cand_dist < r_best_dist));

    // Pipeline valid flags and first-entry marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_v1 <= i_cmd.read_goal;
            r_v2 <= r_v1;
            if (i_cmd.load_query) begin
                r_first <= 1'b1;
            end else if (r_v2) begin
                r_first <= 1'b0;
            end
        end
    end

    // Payload registers of the query, pipeline and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_outcome <= i_cmd.outcome;
            r_px      <= i_point_x;
            r_py      <= i_point_y;
            r_lx      <= i_leader_x;
            r_ly      <= i_leader_y;
        end
        r_idx1 <= i_rd_addr;
        r_idx2 <= r_idx1;
        r_x2   <= gx;
        r_y2   <= gy;
        r_sqx  <= $unsigned(px2);
        r_sqy  <= $unsigned(py2);
        if (take) begin
            r_best_dist <= cand_dist;
            r_best_idx  <= r_idx2;
            r_best_x    <= r_x2;
            r_best_y    <= r_y2;
        end
        if (i_cmd.load_out) begin
            r_out_outcome <= r_outcome;
            r_out_index   <= '0;
            r_out_x       <= '0;
            r_out_y       <= '0;
            case (r_outcome)
                OUT_NEAREST: begin
                    r_out_index <= SLOT_W'(r_best_idx);
                    r_out_x     <= r_best_x;
                    r_out_y     <= r_best_y;
                end
                OUT_LEADER: begin
                    r_out_x <= r_lx;
                    r_out_y <= r_ly;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_outcome          = r_out_outcome;
    assign o_chosen_index     = r_out_index;
    assign o_target_x         = r_out_x;
    assign o_target_y         = r_out_y;

endmodule

FILE: src/nearest_goal_or_leader_select.sv
// Top level of the nearest goal or leader select block.
`timescale 1ns / 1ps
//
// Input channel (i_in_valid / o_in_ready): a transaction with operation 0 stores
// a goal centroid at goal_slot and gives no result; operation 1 is a query that
// gives one result transaction on the output channel (o_out_valid / i_out_ready).
// Configuration channel (i_cfg_valid / o_cfg_ready) writes active_goals; it is
// always ready and should be written only while the block is idle.
// A write is stored on acceptance and input ready stays high. A follower,
// no-neighbor or no-goal query goes from acceptance to the result state, which
// loads the result register once it is free. A leader query reads one table
// entry per cycle from the single memory read port, then waits in the drain
// state for the distance pipeline to empty and loads the result in the result
// state. In both cases the result appears on the edge at which ready returns.
// Results sit in an output register; a new transaction is accepted while a
// result waits, but its own result is held back until the receiver takes the
// older one, and input ready stays low meanwhile.
// Synchronous reset clears the controller and active_goals; the goal table is
// not cleared and must be written before it is searched.
//
module nearest_goal_or_leader_select #(
    parameter int GOAL_CAPACITY = ngls_pkg::GOAL_CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_operation,
    input  logic [ngls_pkg::SLOT_W-1:0]            i_goal_slot,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_point_y,
    input  logic [ngls_pkg::ROLE_W-1:0]            i_role,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_leader_x,
    input  logic signed [ngls_pkg::COORD_BITS-1:0] i_leader_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [ngls_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic [ngls_pkg::SLOT_W-1:0]            o_chosen_index,
    output logic signed [ngls_pkg::COORD_BITS-1:0] o_target_x,
    output logic signed [ngls_pkg::COORD_BITS-1:0] o_target_y,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ngls_pkg::ACTIVE_W-1:0]          i_cfg_active_goals
);
    import ngls_pkg::*;

    localparam int IDX_W = (GOAL_CAPACITY > 1) ? $clog2(GOAL_CAPACITY) : 1;

    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;
    logic [IDX_W-1:0] rd_addr;
    t_outcome         dp_outcome;

    // Controller.
    ngls_ctrl #(
        .GOAL_CAPACITY (GOAL_CAPACITY),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_role             (i_role),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_active_goals (i_cfg_active_goals),
        .o_cmd              (dp_cmd),
        .o_rd_addr          (rd_addr),
        .i_status           (dp_status)
    );

    // Datapath.
    ngls_dpath #(
        .GOAL_CAPACITY (GOAL_CAPACITY),
        .IDX_W         (IDX_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_rd_addr      (rd_addr),
        .o_status       (dp_status),
        .i_goal_slot    (i_goal_slot),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_leader_x     (i_leader_x),
        .i_leader_y     (i_leader_y),
        .o_outcome      (dp_outcome),
        .o_chosen_index (o_chosen_index),
        .o_target_x     (o_target_x),
        .o_target_y     (o_target_y)
    );

    assign o_outcome = dp_outcome;

endmodule

FILE: src/ngls_checker.sv
// Port-level assertions for the nearest goal or leader select block, with its bind.
`timescale 1ns / 1ps

module ngls_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic [ngls_pkg::OUTCOME_W-1:0]         o_outcome,
    input logic [ngls_pkg::SLOT_W-1:0]            o_chosen_index,
    input logic signed [ngls_pkg::COORD_BITS-1:0] o_target_x,
    input logic signed [ngls_pkg::COORD_BITS-1:0] o_target_y
);
    import ngls_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_outcome)
            && $stable(o_chosen_index) && $stable(o_target_x) && $stable(o_target_y))
        else $error("result changed while stalled");

    // Only a nearest-goal result carries an index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome != OUT_NEAREST) |-> o_chosen_index == '0)
        else $error("index set on a non-table result");

    // Default and no-goal results point at the origin.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OUT_DEFAULT || o_outcome == OUT_NO_GOALS)
            |-> o_target_x == '0 && o_target_y == '0)
        else $error("default or no-goal result not at origin");

    // A newly shown result always appears with the input side ready again.
    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while a search is still running");

endmodule

bind nearest_goal_or_leader_select ngls_checker u_ngls_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the nearest goal or leader select block.
`timescale 1ns / 1ps

module tb;
    import ngls_pkg::*;

    localparam int TABLE_DEPTH   = GOAL_CAPACITY_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int IDLE_PERCENT  = 36;

    // Role codes that the package leaves unnamed.
    localparam logic [ROLE_W-1:0] ROLE_ALONE = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_SPARE = 2'd3;

    localparam logic signed [COORD_BITS-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 16'sh7FFF;
    localparam logic signed [COORD_BITS-1:0] C_ZERO = 16'sh0000;

    // One input transaction.
    typedef struct packed {
        logic                         op;
        logic [SLOT_W-1:0]            slot;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [ROLE_W-1:0]            role;
        logic signed [COORD_BITS-1:0] lx;
        logic signed [COORD_BITS-1:0] ly;
    } t_goal_req;

    // One result transaction.
    typedef struct packed {
        t_outcome                     outcome;
        logic [SLOT_W-1:0]            index;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_goal_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed table.
    typedef struct packed {
        t_row_kind          kind;
        logic [ACTIVE_W-1:0] cfg_value;
        t_goal_req          req;
        logic               typed;
        t_goal_result       fixed;
    } t_row;

    localparam t_goal_req    REQ_NONE = '0;
    localparam t_goal_result RES_NONE = '0;

    localparam int DIR_ROWS = 22;
    t_row dir_rows [DIR_ROWS] = '{
        // No goals are active after reset, so a leader gets the no-goal outcome.
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd5, C_MAX, C_MIN, ROLE_LEADER, C_MAX, C_MAX},
          1'b1, '{OUT_NO_GOALS, 6'd0, C_ZERO, C_ZERO}},
        // Followers take the neighbor position, at both extremes.
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, C_ZERO, C_ZERO, ROLE_FOLLOWER, C_MIN, C_MAX},
          1'b1, '{OUT_LEADER, 6'd0, C_MIN, C_MAX}},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd63, 16'sh1234, 16'shEDCB, ROLE_FOLLOWER, C_MAX, C_MIN},
          1'b1, '{OUT_LEADER, 6'd0, C_MAX, C_MIN}},
        // No neighbors, and the unused role code, give the default point.
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, C_MIN, C_MAX, ROLE_ALONE, 16'sh4321, 16'shBCDE},
          1'b1, '{OUT_DEFAULT, 6'd0, C_ZERO, C_ZERO}},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd9, C_MAX, C_MIN, ROLE_SPARE, C_MAX, C_MAX},
          1'b1, '{OUT_DEFAULT, 6'd0, C_ZERO, C_ZERO}},
        // Fill the first entries, with a tie between entries 2 and 3.
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd0, C_MAX, C_MAX, ROLE_LEADER, C_MIN, C_MIN},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd1, C_MIN, C_MIN, ROLE_SPARE, C_MAX, C_MAX},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd2, 16'sh0100, 16'shFF00, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd3, 16'sh0100, 16'shFF00, ROLE_FOLLOWER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd63, 16'sh1234, C_MIN, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        // A single goal is nearest even at the largest distance.
        '{ROW_CFG, 7'd1, REQ_NONE, 1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, C_MIN, C_MIN, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b1, '{OUT_NEAREST, 6'd0, C_MAX, C_MAX}},
        '{ROW_CFG, 7'd4, REQ_NONE, 1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, C_MIN, C_MIN, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b1, '{OUT_NEAREST, 6'd1, C_MIN, C_MIN}},
        // On a tie the lowest index wins.
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, 16'sh0100, 16'shFF00, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b1, '{OUT_NEAREST, 6'd2, 16'sh0100, 16'shFF00}},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, 16'sh00FF, 16'shFF01, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, 16'sh3F00, 16'sh4000, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_WRITE, 6'd1, 16'sh0100, 16'shFF00, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, 16'sh0100, 16'shFF00, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b1, '{OUT_NEAREST, 6'd1, 16'sh0100, 16'shFF00}},
        // Back to no goals at all.
        '{ROW_CFG, 7'd0, REQ_NONE, 1'b0, RES_NONE},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, 16'sh0100, 16'shFF00, ROLE_LEADER, C_ZERO, C_ZERO},
          1'b1, '{OUT_NO_GOALS, 6'd0, C_ZERO, C_ZERO}},
        '{ROW_ITEM, 7'd0, '{OP_QUERY, 6'd0, C_ZERO, C_ZERO, ROLE_FOLLOWER, 16'sh0001, 16'shFFFF},
          1'b0, RES_NONE}
    };

    // Random phases: goal count and number of transactions; large counts run short.
    localparam int PHASES     = 12;
    localparam int CALM_PHASE = 4;
    localparam int PHASE_GOALS [PHASES] = '{64, 3, 127, 1, 10, 65, 2, 0, 6, 33, 4, 12};
    localparam int PHASE_ITEMS [PHASES] = '{40, 130, 30, 130, 130, 30, 130, 100, 130, 100,
                                            130, 130};

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_operation = OP_WRITE;
    logic [SLOT_W-1:0]            i_goal_slot = '0;
    logic signed [COORD_BITS-1:0] i_point_x = '0;
    logic signed [COORD_BITS-1:0] i_point_y = '0;
    logic [ROLE_W-1:0]            i_role = ROLE_LEADER;
    logic signed [COORD_BITS-1:0] i_leader_x = '0;
    logic signed [COORD_BITS-1:0] i_leader_y = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [OUTCOME_W-1:0]         o_outcome;
    logic [SLOT_W-1:0]            o_chosen_index;
    logic signed [COORD_BITS-1:0] o_target_x;
    logic signed [COORD_BITS-1:0] o_target_y;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [ACTIVE_W-1:0]          i_cfg_active_goals = '0;

    // Predictor state: its own copy of the goal table and the goal count.
    logic signed [COORD_BITS-1:0] centroid_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] centroid_y [TABLE_DEPTH];
    logic [ACTIVE_W-1:0]          searched_goals = '0;

    t_goal_result pending_goals [$];
    t_goal_result head;
    int           err_count = 0;
    bit           calm = 1'b0;

    nearest_goal_or_leader_select i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_goal_slot        (i_goal_slot),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_role             (i_role),
        .i_leader_x         (i_leader_x),
        .i_leader_y         (i_leader_y),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_outcome          (o_outcome),
        .o_chosen_index     (o_chosen_index),
        .o_target_x         (o_target_x),
        .o_target_y         (o_target_y),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_active_goals (i_cfg_active_goals)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog in case the block hangs.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Applies one transaction to the predictor; returns 1 when a result follows.
    function automatic bit predict_goal(input t_goal_req req, output t_goal_result res);
        longint dx;
        longint dy;
        longint cand_dist;
        longint best_dist;
        int     count;
        int     best;
        res = RES_NONE;
        res.outcome = OUT_DEFAULT;
        if (req.op == OP_WRITE) begin
            centroid_x[req.slot] = req.px;
            centroid_y[req.slot] = req.py;
            return 1'b0;
        end
        if (req.role == ROLE_LEADER) begin
            count = (searched_goals > TABLE_DEPTH) ? TABLE_DEPTH : int'(searched_goals);
            if (count == 0) begin
                res.outcome = OUT_NO_GOALS;
            end else begin
                best = 0;
                best_dist = 0;
                for (int i = 0; i < count; i++) begin
                    dx = longint'(centroid_x[i]) - longint'(req.px);
                    dy = longint'(centroid_y[i]) - longint'(req.py);
                    cand_dist = dx * dx + dy * dy;
                    if (i == 0 || cand_dist < best_dist) begin
                        best_dist = cand_dist;
                        best = i;
                    end
                end
                res.outcome = OUT_NEAREST;
                res.index = SLOT_W'(best);
                res.x = centroid_x[best];
                res.y = centroid_y[best];
            end
        end else if (req.role == ROLE_FOLLOWER) begin
            res.outcome = OUT_LEADER;
            res.x = req.lx;
            res.y = req.ly;
        end
        return 1'b1;
    endfunction

    // Coordinate mix: extremes, a small cluster around the origin, full range.
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(3))
            0: begin
                case (raw[1:0])
                    2'd0:    return C_MIN;
                    2'd1:    return C_MAX;
                    2'd2:    return C_ZERO;
                    default: return '1;
                endcase
            end
            1:       return COORD_BITS'(int'(raw[5:0]) - 32);
            default: return raw[COORD_BITS-1:0];
        endcase
    endfunction

    // Random transaction aimed at the searched entries, with ties and exact hits.
    function automatic t_goal_req random_request();
        t_goal_req req;
        int        span;
        int        pick;
        int        src;
        span = (searched_goals > TABLE_DEPTH) ? TABLE_DEPTH : int'(searched_goals);
        if (span == 0) span = 1;
        req.op = ($urandom_range(99) < 30) ? OP_WRITE : OP_QUERY;
        req.slot = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(span - 1))
                                            : SLOT_W'($urandom());
        req.px = rand_coord();
        req.py = rand_coord();
        req.lx = rand_coord();
        req.ly = rand_coord();
        pick = $urandom_range(99);
        if (pick < 50)      req.role = ROLE_LEADER;
        else if (pick < 70) req.role = ROLE_FOLLOWER;
        else if (pick < 85) req.role = ROLE_ALONE;
        else                req.role = ROLE_SPARE;
        // Copy an existing goal: a duplicate entry on a write, an exact hit on a query.
        src = $urandom_range(span - 1);
        if ($urandom_range(4) == 0) begin
            req.px = centroid_x[src];
            req.py = centroid_y[src];
        end
        return req;
    endfunction

    // Drives one input transaction and records its expected result on acceptance.
    task automatic send_request(input t_goal_req req, input bit typed,
                                input t_goal_result fixed);
        t_goal_result want;
        bit           gives;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= req.op;
        i_goal_slot <= req.slot;
        i_point_x   <= req.px;
        i_point_y   <= req.py;
        i_role      <= req.role;
        i_leader_x  <= req.lx;
        i_leader_y  <= req.ly;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gives = predict_goal(req, want);
        if (gives) pending_goals.push_back(typed ? fixed : want);
    endtask

    // Waits until every result is back and any write still in flight has settled.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_goals.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the goal count over the configuration channel.
    task automatic set_active_goals(input logic [ACTIVE_W-1:0] value);
        i_cfg_valid        <= 1'b1;
        i_cfg_active_goals <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        searched_goals = value;
    endtask

    task automatic report_field(input string name, input logic [COORD_BITS-1:0] want,
                                input logic [COORD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
            err_count++;
        end
    endtask

    // Receiver back-pressure, with no stalls during the calm phase.
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_goals.size() == 0) begin
                $display("%0t: unexpected result, expected none actual outcome %0d",
                         $realtime, o_outcome);
                err_count++;
            end else begin
                head = pending_goals.pop_front();
                report_field("outcome", COORD_BITS'(head.outcome), COORD_BITS'(o_outcome));
                report_field("chosen_index", COORD_BITS'(head.index),
                             COORD_BITS'(o_chosen_index));
                report_field("target_x", head.x, o_target_x);
                report_field("target_y", head.y, o_target_y);
            end
        end
    end

    // Main sequence: reset, directed table, table fill, random phases, wrap-up.
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            centroid_x[i] = '0;
            centroid_y[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_block();
                set_active_goals(dir_rows[r].cfg_value);
            end else begin
                send_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].fixed);
            end
        end

        // Write every entry so that any goal count searches only written entries.
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            send_request('{OP_WRITE, SLOT_W'(s), rand_coord(), rand_coord(),
                           ROLE_W'($urandom()), rand_coord(), rand_coord()},
                         1'b0, RES_NONE);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            set_active_goals(ACTIVE_W'(PHASE_GOALS[p]));
            calm = (p == CALM_PHASE);
            repeat (PHASE_ITEMS[p]) send_request(random_request(), 1'b0, RES_NONE);
        end
        calm = 1'b0;

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_goals.size() != 0) begin
            $display("%0t: %0d results expected but never delivered", $realtime,
                     pending_goals.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
